// ===== sv/bols_pkg.sv =====
// Shared constants and types for the bounded ordered list store.
// Used by bols_ctrl, bols_dp and bounded_ordered_list_store; no dependencies.

package bols_pkg;

  // default memory depth and field widths
  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int CNT_W        = 5;
  localparam int FUNC_W       = 3;
  localparam int ERR_W        = 2;
  localparam int IN_W         = 40;  // func, value, position
  localparam int OUT_W        = 40;  // read_word, entry_count, is_empty, error_code

  localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd10;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE    = 3'd1;
  localparam logic [FUNC_W-1:0] OP_INSERT    = 3'd2;
  localparam logic [FUNC_W-1:0] OP_OVERWRITE = 3'd3;
  localparam logic [FUNC_W-1:0] OP_READ      = 3'd4;
  localparam logic [FUNC_W-1:0] OP_REVERSE   = 3'd5;
  localparam logic [FUNC_W-1:0] OP_CLEAR     = 3'd6;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

  // memory write data select
  localparam logic [1:0] WSEL_VALUE = 2'd0;
  localparam logic [1:0] WSEL_RDATA = 2'd1;
  localparam logic [1:0] WSEL_HOLD  = 2'd2;

  // entry count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic             in_take;
    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [1:0]       wsel;
    logic             re;
    logic [CNT_W-1:0] raddr;
    logic             hold_ld;
    logic [1:0]       cnt_op;
    logic             out_ld;
    logic             rd_keep;
    logic [ERR_W-1:0] err;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
    logic              full;
    logic              out_free;
  } dp_status_t;

endpackage

// ===== sv/bounded_ordered_list_store.sv =====
// Top level of the bounded ordered list store.
// Depends on bols_pkg, bols_ctrl and bols_dp.
//
// Usage:
//   in_* stream carries one operation word: append, remove last, insert,
//   overwrite, read, reverse or clear. Each word yields exactly one result
//   word on out_* with the read entry, the count after the operation, an
//   empty flag and an error code. cfg_wen/cfg_wdata set the capacity limit
//   (saturated at CAPACITY); write it only while the block is idle.
// Sequencing:
//   one operation at a time; the controller walks the entry memory, which
//   has one write and one registered read port.
//   insert below the end shifts the entries from position upward by one
//   slot, top first, then writes the value; reverse swaps entry pairs from
//   both ends toward the middle; the other operations need no walk.
//   the result is registered into the output register that drives out_*.
// Reset: count clears, limit returns to 10, no result pending.
//   Entry memory is not cleared; entries are read only after being written.
// Stall: the result waits in the output register; the next word is still
//   accepted, and only its own result waits until the register frees up.

module bounded_ordered_list_store #(
  parameter int CAPACITY = bols_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: capacity limit
  input  logic                       cfg_wen,
  input  logic [bols_pkg::CNT_W-1:0] cfg_wdata,
  // operation words
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bols_pkg::IN_W-1:0]  in_tdata,   // func[2:0], value[34:3], position[39:35]
  // result words
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bols_pkg::OUT_W-1:0] out_tdata   // read_word[31:0], entry_count[36:32],
                                                 // is_empty[37], error_code[39:38]
);
  import bols_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  bols_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and result path
  bols_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/bols_dp.sv =====
// Datapath of the list store: entry memory, operand and count registers, output word.
// Depends on bols_pkg; driven by bols_ctrl through dp_cmd_t.

module bols_dp #(
  parameter int CAPACITY = bols_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wen,
  input  logic [bols_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic [bols_pkg::IN_W-1:0]   in_tdata,
  input  bols_pkg::dp_cmd_t           cmd,
  output bols_pkg::dp_status_t        status,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bols_pkg::OUT_W-1:0]  out_tdata
);
  import bols_pkg::*;

  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntMax = (2 ** CNT_W) - 1;
  localparam logic [CNT_W-1:0] CapTop = CNT_W'((CAPACITY > CntMax) ? CntMax : CAPACITY);

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]  lim_r;
  logic [FUNC_W-1:0] func_r;
  logic [WORD_W-1:0] value_r;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] hold_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [CNT_W-1:0]  eff_lim;
  logic [WORD_W-1:0] wdata;

  // capacity limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RESET;
    end else if (cfg_wen) begin
      lim_r <= cfg_wdata;
    end
  end

  // operand capture on accept
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      func_r  <= in_tdata[FUNC_W-1:0];
      value_r <= in_tdata[FUNC_W+WORD_W-1:FUNC_W];
      pos_r   <= in_tdata[FUNC_W+WORD_W+CNT_W-1:FUNC_W+WORD_W];
    end
  end

  // entry count
  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + 1'b1;
      CNT_DEC: cnt_nxt = cnt_r - 1'b1;
      CNT_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // write data select
  always_comb begin
    case (cmd.wsel)
      WSEL_RDATA: wdata = rd_data_r;
      WSEL_HOLD:  wdata = hold_r;
      default:    wdata = value_r;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[AW'(cmd.waddr)] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rd_data_r <= mem[AW'(cmd.raddr)];
    end
  end

  // holding word for swaps
  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      hold_r <= rd_data_r;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= {cmd.err, (cnt_r == '0), cnt_r,
                     (cmd.rd_keep ? rd_data_r : {WORD_W{1'b0}})};
    end
  end

  // status toward the controller
  assign eff_lim         = (lim_r > CapTop) ? CapTop : lim_r;
  assign status.func     = func_r;
  assign status.pos      = pos_r;
  assign status.cnt      = cnt_r;
  assign status.full     = (cnt_r >= eff_lim);
  assign status.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/bols_ctrl.sv =====
// Controller of the list store: decodes the operation, sequences shifts and swaps.
// Depends on bols_pkg; commands bols_dp through dp_cmd_t.

module bols_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bols_pkg::dp_status_t status,
  output bols_pkg::dp_cmd_t    cmd
);
  import bols_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_INS_SH  = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_REV_RB  = 3'd4;
  localparam logic [2:0] S_REV_WA  = 3'd5;
  localparam logic [2:0] S_REV_WB  = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0] lo_inc, hi_dec;
  logic             more_swaps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= ERR_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  // next swap pair still lies below the middle
  assign lo_inc     = lo_r + 1'b1;
  assign hi_dec     = hi_r - 1'b1;
  assign more_swaps = (lo_inc < hi_dec);

  assign in_ready = (state_r == S_IDLE);

  // state machine and command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    err_nxt   = err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        err_nxt   = ERR_OK;
        state_nxt = S_RESP;
        unique case (status.func)
          OP_APPEND: begin
            if (status.full) begin
              err_nxt = ERR_FULL;
            end else begin
              cmd.we     = 1'b1;
              cmd.waddr  = status.cnt;
              cmd.wsel   = WSEL_VALUE;
              cmd.cnt_op = CNT_INC;
            end
          end
          OP_REMOVE: begin
            if (status.cnt == '0) begin
              err_nxt = ERR_EMPTY;
            end else begin
              cmd.cnt_op = CNT_DEC;
            end
          end
          OP_INSERT: begin
            if (status.pos > status.cnt) begin
              err_nxt = ERR_RANGE;
            end else if (status.full) begin
              err_nxt = ERR_FULL;
            end else if (status.pos == status.cnt) begin
              cmd.we     = 1'b1;
              cmd.waddr  = status.pos;
              cmd.wsel   = WSEL_VALUE;
              cmd.cnt_op = CNT_INC;
            end else begin
              // start shifting from the top entry downward
              cmd.re    = 1'b1;
              cmd.raddr = status.cnt - 1'b1;
              hi_nxt    = status.cnt;
              state_nxt = S_INS_SH;
            end
          end
          OP_OVERWRITE: begin
            if (status.pos >= status.cnt) begin
              err_nxt = ERR_RANGE;
            end else begin
              cmd.we    = 1'b1;
              cmd.waddr = status.pos;
              cmd.wsel  = WSEL_VALUE;
            end
          end
          OP_READ: begin
            if (status.pos >= status.cnt) begin
              err_nxt = ERR_RANGE;
            end else begin
              cmd.re    = 1'b1;
              cmd.raddr = status.pos;
            end
          end
          OP_REVERSE: begin
            if (status.cnt >= 5'd2) begin
              cmd.re    = 1'b1;
              cmd.raddr = '0;
              lo_nxt    = '0;
              hi_nxt    = status.cnt - 1'b1;
              state_nxt = S_REV_RB;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end
      S_INS_SH: begin
        // move entry hi-1 up to hi, fetch the next one below
        cmd.we    = 1'b1;
        cmd.waddr = hi_r;
        cmd.wsel  = WSEL_RDATA;
        if (hi_dec > status.pos) begin
          cmd.re    = 1'b1;
          cmd.raddr = hi_r - 5'd2;
          hi_nxt    = hi_dec;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.we     = 1'b1;
        cmd.waddr  = status.pos;
        cmd.wsel   = WSEL_VALUE;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_RESP;
      end
      S_REV_RB: begin
        cmd.re      = 1'b1;
        cmd.raddr   = hi_r;
        cmd.hold_ld = 1'b1;
        state_nxt   = S_REV_WA;
      end
      S_REV_WA: begin
        // low slot takes the high word, prefetch next low word
        cmd.we    = 1'b1;
        cmd.waddr = lo_r;
        cmd.wsel  = WSEL_RDATA;
        if (more_swaps) begin
          cmd.re    = 1'b1;
          cmd.raddr = lo_inc;
        end
        state_nxt = S_REV_WB;
      end
      S_REV_WB: begin
        // high slot takes the held low word, prefetch next high word
        cmd.we    = 1'b1;
        cmd.waddr = hi_r;
        cmd.wsel  = WSEL_HOLD;
        lo_nxt    = lo_inc;
        hi_nxt    = hi_dec;
        if (more_swaps) begin
          cmd.hold_ld = 1'b1;
          cmd.re      = 1'b1;
          cmd.raddr   = hi_dec;
          state_nxt   = S_REV_WA;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.err     = err_r;
          cmd.rd_keep = (status.func == OP_READ) && (err_r == ERR_OK);
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
